// ----- sv/wsg_pkg.sv -----
// ----------------------------------------------------------------------------
// wsg_pkg
// Shared types, codes and constants of the waveform sample generator, with
// the quarter-wave sine table worked out at elaboration.
// ----------------------------------------------------------------------------
package wsg_pkg;

    localparam int TABLE_DEPTH   = 4096;
    localparam int TBL_AW        = $clog2(TABLE_DEPTH);
    localparam int SIZE_W        = 13;
    localparam int STEP_SLOTS    = 8;
    localparam int SLOT_AW       = $clog2(STEP_SLOTS);
    localparam int SINE_ROM_BITS = 10;
    localparam int ROM_DEPTH     = (1 << SINE_ROM_BITS) + 1;
    localparam int ROM_AW        = SINE_ROM_BITS + 1;
    localparam int DW            = 34;
    localparam int RATE_W        = 24;
    localparam int MILLI         = 1000;

    localparam logic signed [63:0] SIN_C0 = 64'sd1686629713;
    localparam logic signed [63:0] SIN_C1 = 64'sd693598668;
    localparam logic signed [63:0] SIN_C2 = 64'sd85569306;
    localparam logic signed [63:0] SIN_C3 = 64'sd5026995;
    localparam logic signed [63:0] SIN_C4 = 64'sd172272;
    localparam logic signed [63:0] SIN_C5 = 64'sd3864;
    localparam logic signed [63:0] SIN_C6 = 64'sd61;
    localparam logic signed [63:0] Q30_ONE = 64'sd1 <<< 30;

    typedef enum logic [2:0] {
        MODE_ZERO         = 3'd0,
        MODE_SINE         = 3'd1,
        MODE_COSINE       = 3'd2,
        MODE_SQUARE       = 3'd3,
        MODE_TRIANGLE     = 3'd4,
        MODE_TABLE_CYCLE  = 3'd5,
        MODE_TABLE_SECOND = 3'd6
    } mode_t;

    typedef enum logic [1:0] {
        OP_GENERATE    = 2'd0,
        OP_WRITE_TABLE = 2'd1,
        OP_WRITE_STEP  = 2'd2
    } opcode_t;

    typedef enum logic [2:0] {
        REG_MODE       = 3'd0,
        REG_AMPLITUDE  = 3'd1,
        REG_FREQUENCY  = 3'd2,
        REG_PHASE      = 3'd3,
        REG_RATE       = 3'd4,
        REG_TABLE_SIZE = 3'd5,
        REG_STEP_COUNT = 3'd6
    } reg_index_t;

    typedef enum logic {
        ARITH_DIV,
        ARITH_MULMOD
    } arith_op_t;

    typedef struct packed {
        arith_op_t op;
        logic      bit_in;
    } arith_ctl_t;

    typedef enum logic [4:0] {
        S_IDLE, S_SETUP, S_NMOD, S_WITHIN, S_FMOD, S_MULMOD, S_PROD, S_IDX,
        S_READ, S_TRES, S_TURN, S_ROM, S_WAVE, S_AMP, S_ENV, S_MLO, S_MHI
    } state_t;

    typedef logic [30:0] sine_rom_t [ROM_DEPTH];

    function automatic logic signed [63:0] mul_q30(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [63:0] p;
        p = a * b;
        return p >>> 30;
    endfunction

    function automatic logic [30:0] quarter_sine(input int a);
        logic signed [63:0] x;
        logic signed [63:0] s;
        logic signed [63:0] p;
        x = 64'(a) <<< (30 - SINE_ROM_BITS);
        s = mul_q30(x, x);
        p = SIN_C6;
        p = mul_q30(p, s) - SIN_C5;
        p = mul_q30(p, s) + SIN_C4;
        p = mul_q30(p, s) - SIN_C3;
        p = mul_q30(p, s) + SIN_C2;
        p = mul_q30(p, s) - SIN_C1;
        p = mul_q30(p, s) + SIN_C0;
        p = mul_q30(p, x);
        if (p < 0)
        begin
            p = 64'sd0;
        end
        if (p > Q30_ONE)
        begin
            p = Q30_ONE;
        end
        return p[30:0];
    endfunction

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t r;
        for (int i = 0; i < ROM_DEPTH; i++)
        begin
            r[i] = quarter_sine(i);
        end
        return r;
    endfunction

endpackage

// ----- sv/wsg_arith.sv -----
// ----------------------------------------------------------------------------
// wsg_arith
// Shared modular step unit: one restoring-division step or one step of a
// shift-and-add modular multiply, chosen by the sequencer each cycle.
// ----------------------------------------------------------------------------
module wsg_arith (
    input  wsg_pkg::arith_ctl_t       ctl,
    input  logic [wsg_pkg::DW-1:0]    rem,
    input  logic [wsg_pkg::DW-1:0]    den,
    input  logic [wsg_pkg::DW-1:0]    addend,
    output logic [wsg_pkg::DW-1:0]    rem_next,
    output logic                      q_bit
);
    import wsg_pkg::*;

    logic [DW:0] t;
    logic [DW:0] t1;
    logic [DW:0] u;
    logic [DW:0] u1;
    logic        ge;

    always_comb
    begin
        if (ctl.op == ARITH_DIV)
        begin
            t = {rem, ctl.bit_in};
        end
        else
        begin
            t = {rem, 1'b0};
        end
        ge = (t >= {1'b0, den});
        t1 = ge ? t - {1'b0, den} : t;
        u  = {1'b0, t1[DW-1:0]} + {1'b0, addend};
        u1 = (u >= {1'b0, den}) ? u - {1'b0, den} : u;
        q_bit = ge;
        if (ctl.op == ARITH_MULMOD && ctl.bit_in)
        begin
            rem_next = u1[DW-1:0];
        end
        else
        begin
            rem_next = t1[DW-1:0];
        end
    end

endmodule

// ----- sv/wsg_sine_rom.sv -----
// ----------------------------------------------------------------------------
// wsg_sine_rom
// Quarter-wave sine table in Q30, one registered read a cycle.
// ----------------------------------------------------------------------------
module wsg_sine_rom (
    input  logic                        clk,
    input  logic [wsg_pkg::ROM_AW-1:0]  addr,
    output logic [30:0]                 data
);
    import wsg_pkg::*;

    localparam sine_rom_t SineRom = build_sine_rom();

    always_ff @(posedge clk)
    begin
        data <= SineRom[addr];
    end

endmodule

// ----- sv/wsg_wave_ram.sv -----
// ----------------------------------------------------------------------------
// wsg_wave_ram
// Wave table store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module wsg_wave_ram (
    input  logic                        clk,
    input  logic                        we,
    input  logic [wsg_pkg::TBL_AW-1:0]  waddr,
    input  logic [31:0]                 wdata,
    input  logic [wsg_pkg::TBL_AW-1:0]  raddr,
    output logic [31:0]                 rdata
);
    import wsg_pkg::*;

    logic [31:0] mem [TABLE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/waveform_sample_generator.sv -----
// ----------------------------------------------------------------------------
// waveform_sample_generator
// One direct digital synthesis channel: sine, cosine, square, triangle or
// wavetable sample for a given sample index.
// ----------------------------------------------------------------------------
// Use: pulse start with an item while busy is low. Opcode generate yields one
// beat on sample/clipped, marked by done for one cycle; it cannot be held off.
// Table and step writes complete at the accepting edge and yield no beat.
// The user writes configuration through cfg_write/cfg_index/cfg_data while
// idle; the block does not enforce this. Path of a generate item: a zero
// result (mode zero or the unused mode code, zero rate, empty table) arrives
// in the cycle after acceptance. Otherwise a setup state, then the shared
// modular step unit works out n mod D, n mod rate, f mod D and the modular
// multiply, then the index division, index clamp and table read in table
// modes, or the fraction steps, sine read, wave shaping, amplitude, envelope
// steps and both multiply halves in wave modes. The beat comes in the same
// cycle as busy falls; busy stays high for all of it; one item at a time.
// Reset puts the registers at their documented defaults and the sequencer
// idle; wave table and step slots hold nothing defined until written.
// ----------------------------------------------------------------------------
module waveform_sample_generator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    opcode,
    input  logic [47:0]                   sample_index,
    input  logic [11:0]                   entry_address,
    input  logic signed [31:0]            entry_value,
    input  logic [2:0]                    step_slot,
    input  logic [23:0]                   step_time_samples,
    input  logic signed [23:0]            step_coefficient,
    input  logic                          cfg_write,
    input  logic [2:0]                    cfg_index,
    input  logic [31:0]                   cfg_data,
    output logic                          done,
    output logic signed [31:0]            sample,
    output logic                          clipped
);
    import wsg_pkg::*;

    // configuration
    logic [2:0]         mode_reg;
    logic signed [31:0] amp_reg;
    logic [31:0]        freq_reg;
    logic [15:0]        offset_reg;
    logic [RATE_W-1:0]  rate_reg;
    logic [SIZE_W-1:0]  size_reg;
    logic [3:0]         stepcnt_reg;

    logic [23:0] step_time_mem [STEP_SLOTS];
    logic [23:0] step_gain_mem [STEP_SLOTS];

    state_t              state_reg, state_next;
    logic [5:0]          cnt_reg, cnt_next;
    logic [47:0]         sh_reg, sh_next;
    logic [DW-1:0]       rem_reg, rem_next;
    logic [DW-1:0]       d_reg, d_next;
    logic [DW-1:0]       nmod_reg, nmod_next;
    logic [RATE_W-1:0]   within_reg, within_next;
    logic [DW-1:0]       p_reg, p_next;
    logic [31:0]         q_reg, q_next;
    logic [TBL_AW-1:0]   idx_reg, idx_next;
    logic [31:0]         ph_reg, ph_next;
    logic signed [31:0]  v_reg, v_next;
    logic signed [62:0]  z_reg, z_next;
    logic signed [27:0]  m_reg, m_next;
    logic [3:0]          env_reg, env_next;
    logic [58:0]         lo_reg, lo_next;
    logic                done_reg, done_next;
    logic signed [31:0]  sample_reg, sample_next;
    logic                clipped_reg, clipped_next;

    arith_ctl_t     actl;
    logic [DW-1:0]  aden;
    logic [DW-1:0]  arem_next;
    logic           aq_bit;

    logic [30:0]          rom_data;
    logic [ROM_AW-1:0]    rom_addr;
    logic [31:0]          ram_rdata;

    logic                 accept;
    logic                 table_mode;
    logic [SIZE_W-1:0]    size_eff;
    logic [3:0]           step_lim;
    logic [SIZE_W-1:0]    q_fin;
    logic [31:0]          q_full;
    logic [46:0]          prod;
    logic [62:0]          zabs;
    logic [27:0]          mabs;
    logic                 neg;
    logic [56:0]          hi;
    logic [57:0]          acc;
    logic [43:0]          mag;
    logic [SINE_ROM_BITS-1:0] quarter_pos;
    logic signed [33:0]   tri_val;

    assign accept     = start && !busy;
    assign busy       = (state_reg != S_IDLE);
    assign table_mode = (mode_reg == MODE_TABLE_CYCLE) || (mode_reg == MODE_TABLE_SECOND);
    assign size_eff   = (size_reg > SIZE_W'(TABLE_DEPTH)) ? SIZE_W'(TABLE_DEPTH) : size_reg;
    assign step_lim   = (stepcnt_reg > 4'(STEP_SLOTS)) ? 4'(STEP_SLOTS) : stepcnt_reg;

    assign done    = done_reg;
    assign sample  = sample_reg;
    assign clipped = clipped_reg;

    // configuration port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= 3'(MODE_ZERO);
            amp_reg     <= '0;
            freq_reg    <= 32'd50000;
            offset_reg  <= '0;
            rate_reg    <= RATE_W'(4000);
            size_reg    <= SIZE_W'(1);
            stepcnt_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_MODE:       mode_reg    <= cfg_data[2:0];
                REG_AMPLITUDE:  amp_reg     <= cfg_data;
                REG_FREQUENCY:  freq_reg    <= cfg_data;
                REG_PHASE:      offset_reg  <= cfg_data[15:0];
                REG_RATE:       rate_reg    <= cfg_data[RATE_W-1:0];
                REG_TABLE_SIZE: size_reg    <= cfg_data[SIZE_W-1:0];
                REG_STEP_COUNT: stepcnt_reg <= cfg_data[3:0];
                default:        ;
            endcase
        end
    end

    // step slots
    always_ff @(posedge clk)
    begin
        if (accept && opcode == OP_WRITE_STEP && 32'(step_slot) < STEP_SLOTS)
        begin
            step_time_mem[SLOT_AW'(step_slot)] <= step_time_samples;
            step_gain_mem[SLOT_AW'(step_slot)] <= step_coefficient;
        end
    end

    wsg_wave_ram u_ram (
        .clk   (clk),
        .we    (accept && opcode == OP_WRITE_TABLE && 32'(entry_address) < TABLE_DEPTH),
        .waddr (TBL_AW'(entry_address)),
        .wdata (entry_value),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    assign quarter_pos = ph_reg[29:30-SINE_ROM_BITS];
    assign rom_addr = ph_reg[30] ? ROM_AW'(ROM_DEPTH - 1) - {1'b0, quarter_pos}
                                 : {1'b0, quarter_pos};

    wsg_sine_rom u_rom (
        .clk  (clk),
        .addr (rom_addr),
        .data (rom_data)
    );

    always_comb
    begin
        actl.op     = (state_reg == S_MULMOD) ? ARITH_MULMOD : ARITH_DIV;
        actl.bit_in = sh_reg[47];
        if (state_reg == S_WITHIN || (state_reg == S_IDX && mode_reg == MODE_TABLE_SECOND))
        begin
            aden = DW'(rate_reg);
        end
        else
        begin
            aden = d_reg;
        end
    end

    wsg_arith u_arith (
        .ctl      (actl),
        .rem      (rem_reg),
        .den      (aden),
        .addend   (nmod_reg),
        .rem_next (arem_next),
        .q_bit    (aq_bit)
    );

    assign q_full = {q_reg[30:0], aq_bit};
    assign q_fin  = q_full[SIZE_W-1:0];
    assign prod   = (mode_reg == MODE_TABLE_SECOND) ? 47'(within_reg) * 47'(size_eff)
                                                    : 47'(p_reg) * 47'(size_eff);
    assign zabs   = z_reg[62] ? 63'(-z_reg) : 63'(z_reg);
    assign mabs   = m_reg[27] ? 28'(-m_reg) : 28'(m_reg);
    assign neg    = z_reg[62] != m_reg[27];
    assign hi     = zabs[61:32] * mabs[26:0];
    assign acc    = 58'(hi) + 58'(lo_reg[58:32]);
    assign mag    = acc[57:14];
    assign tri_val = ph_reg[31] ? (34'sd3 <<< 30) - $signed({2'b0, ph_reg})
                                : $signed({2'b0, ph_reg}) - (34'sd1 <<< 30);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            done_reg    <= 1'b0;
            clipped_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            done_reg    <= done_next;
            clipped_reg <= clipped_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg    <= cnt_next;
        sh_reg     <= sh_next;
        rem_reg    <= rem_next;
        d_reg      <= d_next;
        nmod_reg   <= nmod_next;
        within_reg <= within_next;
        p_reg      <= p_next;
        q_reg      <= q_next;
        idx_reg    <= idx_next;
        ph_reg     <= ph_next;
        v_reg      <= v_next;
        z_reg      <= z_next;
        m_reg      <= m_next;
        env_reg    <= env_next;
        lo_reg     <= lo_next;
        sample_reg <= sample_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg - 6'd1;
        sh_next      = {sh_reg[46:0], 1'b0};
        rem_next     = arem_next;
        d_next       = d_reg;
        nmod_next    = nmod_reg;
        within_next  = within_reg;
        p_next       = p_reg;
        q_next       = q_full;
        idx_next     = idx_reg;
        ph_next      = ph_reg;
        v_next       = v_reg;
        z_next       = z_reg;
        m_next       = m_reg;
        env_next     = env_reg;
        lo_next      = lo_reg;
        done_next    = 1'b0;
        clipped_next = 1'b0;
        sample_next  = sample_reg;
        case (state_reg)
            S_IDLE:
            begin
                rem_next = '0;
                sh_next  = sample_index;
                cnt_next = 6'd47;
                if (accept && opcode == OP_GENERATE)
                begin
                    if (rate_reg == '0 || mode_reg == MODE_ZERO || mode_reg > MODE_TABLE_SECOND
                        || (table_mode && size_eff == '0))
                    begin
                        done_next   = 1'b1;
                        sample_next = '0;
                    end
                    else
                    begin
                        state_next = S_SETUP;
                    end
                end
            end
            S_SETUP:
            begin
                d_next     = DW'(rate_reg) * DW'(MILLI);
                rem_next   = '0;
                sh_next    = sh_reg;
                cnt_next   = 6'd47;
                state_next = S_NMOD;
            end
            S_NMOD:
            begin
                if (cnt_reg == 6'd0)
                begin
                    nmod_next  = arem_next;
                    rem_next   = '0;
                    sh_next    = {arem_next, 14'b0};
                    cnt_next   = 6'(DW - 1);
                    state_next = S_WITHIN;
                end
            end
            S_WITHIN:
            begin
                if (cnt_reg == 6'd0)
                begin
                    within_next = arem_next[RATE_W-1:0];
                    rem_next    = '0;
                    sh_next     = {freq_reg, 16'b0};
                    cnt_next    = 6'd31;
                    state_next  = S_FMOD;
                end
            end
            S_FMOD:
            begin
                if (cnt_reg == 6'd0)
                begin
                    rem_next   = '0;
                    sh_next    = {arem_next, 14'b0};
                    cnt_next   = 6'(DW - 1);
                    state_next = S_MULMOD;
                end
            end
            S_MULMOD:
            begin
                if (cnt_reg == 6'd0)
                begin
                    p_next   = arem_next;
                    q_next   = '0;
                    cnt_next = 6'd31;
                    sh_next  = '0;
                    if (table_mode)
                    begin
                        state_next = S_PROD;
                    end
                    else
                    begin
                        state_next = S_TURN;
                    end
                end
            end
            S_PROD:
            begin
                sh_next    = {prod, 1'b0};
                rem_next   = '0;
                q_next     = '0;
                cnt_next   = 6'd46;
                state_next = S_IDX;
            end
            S_IDX:
            begin
                if (cnt_reg == 6'd0)
                begin
                    // clamp to the last entry in use
                    if (q_fin >= size_eff)
                    begin
                        idx_next = TBL_AW'(size_eff - SIZE_W'(1));
                    end
                    else
                    begin
                        idx_next = TBL_AW'(q_fin);
                    end
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_TRES;
            end
            S_TRES:
            begin
                sample_next = ram_rdata;
                done_next   = 1'b1;
                state_next  = S_IDLE;
            end
            S_TURN:
            begin
                if (cnt_reg == 6'd0)
                begin
                    ph_next = q_full + {offset_reg, 16'b0}
                            + ((mode_reg == MODE_COSINE) ? 32'h4000_0000 : 32'h0);
                    state_next = S_ROM;
                end
            end
            S_ROM:
            begin
                state_next = S_WAVE;
            end
            S_WAVE:
            begin
                case (mode_reg)
                    MODE_SINE, MODE_COSINE:
                        v_next = ph_reg[31] ? -$signed({1'b0, rom_data})
                                            : $signed({1'b0, rom_data});
                    MODE_SQUARE:
                        v_next = ph_reg[31] ? -(32'sd1 <<< 30) : (32'sd1 <<< 30);
                    default:
                        v_next = 32'(tri_val);
                endcase
                state_next = S_AMP;
            end
            S_AMP:
            begin
                z_next     = 63'(64'(v_reg) * 64'(amp_reg));
                m_next     = 28'sd65536;
                env_next   = '0;
                state_next = S_ENV;
            end
            S_ENV:
            begin
                if (env_reg < step_lim)
                begin
                    if (within_reg >= step_time_mem[SLOT_AW'(env_reg)])
                    begin
                        m_next = m_reg + 28'($signed(step_gain_mem[SLOT_AW'(env_reg)]));
                    end
                    env_next = env_reg + 4'd1;
                end
                else
                begin
                    state_next = S_MLO;
                end
            end
            S_MLO:
            begin
                lo_next    = zabs[31:0] * mabs[26:0];
                state_next = S_MHI;
            end
            S_MHI:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
                if (!neg)
                begin
                    if (mag > 44'h0_7FFF_FFFF)
                    begin
                        sample_next  = 32'sh7FFF_FFFF;
                        clipped_next = 1'b1;
                    end
                    else
                    begin
                        sample_next = mag[31:0];
                    end
                end
                else
                begin
                    if (mag > 44'h0_8000_0000)
                    begin
                        sample_next  = 32'sh8000_0000;
                        clipped_next = 1'b1;
                    end
                    else
                    begin
                        sample_next = 32'(32'h0 - mag[31:0]);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_done_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while sequencer busy");

    a_write_no_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && opcode != OP_GENERATE) |=> !done)
        else $error("write item produced a result beat");

    a_clip_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        clipped |-> (done && (sample == 32'sh7FFF_FFFF || sample == 32'sh8000_0000)))
        else $error("clip flag without saturated sample");

    a_zero_quick: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && opcode == OP_GENERATE && rate_reg == '0) |=> (done && sample == '0))
        else $error("zero rate did not give an immediate zero");

endmodule

// ----- tb/sv/tb_waveform_sample_generator.sv -----
// ----------------------------------------------------------------------------
// tb_waveform_sample_generator
// Self-checking bench for one waveform sample generator channel: directed
// mode and corner cases, then random items under varying configurations and
// sender gaps, each sample beat compared with an in-bench bit-exact predictor.
// ----------------------------------------------------------------------------
module tb_waveform_sample_generator;
    import wsg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam int         CYCLE_LIMIT  = 3000000;
    localparam int         DRAIN_WAIT   = 200;
    localparam int         FILL_DEPTH   = 64;
    localparam int         RANDOM_ITEMS = 17;

    typedef struct {
        logic [1:0]         op;
        logic [47:0]        n;
        logic [11:0]        addr;
        logic signed [31:0] value;
        logic [2:0]         slot;
        logic [23:0]        onset;
        logic signed [23:0] gain;
    } gen_cmd_t;

    typedef struct {
        logic signed [31:0] sample;
        logic               clipped;
    } sample_beat_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [1:0]           opcode = '0;
    logic [47:0]          sample_index = '0;
    logic [11:0]          entry_address = '0;
    logic signed [31:0]   entry_value = '0;
    logic [2:0]           step_slot = '0;
    logic [23:0]          step_time_samples = '0;
    logic signed [23:0]   step_coefficient = '0;
    logic                 cfg_write = 1'b0;
    logic [2:0]           cfg_index = '0;
    logic [31:0]          cfg_data = '0;
    logic                 done;
    logic signed [31:0]   sample;
    logic                 clipped;

    // predictor state
    logic [2:0]           cur_mode;
    logic [31:0]          cur_amp;
    logic [31:0]          cur_freq;
    logic [15:0]          cur_phase;
    logic [23:0]          cur_rate;
    logic [12:0]          cur_size;
    logic [3:0]           cur_steps;
    logic [31:0]          wave_mem [TABLE_DEPTH];
    logic [23:0]          onset_mem [STEP_SLOTS];
    logic [23:0]          gain_mem [STEP_SLOTS];
    logic signed [63:0]   quarter_wave [ROM_DEPTH];

    sample_beat_t         pending_samples[$];
    int                   mismatches = 0;
    int                   idle_pct = 0;
    longint               cycles = 0;

    waveform_sample_generator u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .opcode(opcode),
        .sample_index(sample_index), .entry_address(entry_address),
        .entry_value(entry_value), .step_slot(step_slot),
        .step_time_samples(step_time_samples), .step_coefficient(step_coefficient),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .done(done), .sample(sample), .clipped(clipped)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL waveform_sample_generator");
            $finish;
        end
    end

    function automatic logic signed [63:0] floor_q30(logic signed [63:0] a,
                                                     logic signed [63:0] b);
        logic signed [63:0] prod;
        prod = a * b;
        return prod >>> 30;
    endfunction

    function automatic logic signed [63:0] poly_sine(int a);
        logic signed [63:0] x;
        logic signed [63:0] sq;
        logic signed [63:0] acc;
        x = 64'(a) <<< (30 - SINE_ROM_BITS);
        sq = floor_q30(x, x);
        acc = 64'sd61;
        acc = floor_q30(acc, sq) - 64'sd3864;
        acc = floor_q30(acc, sq) + 64'sd172272;
        acc = floor_q30(acc, sq) - 64'sd5026995;
        acc = floor_q30(acc, sq) + 64'sd85569306;
        acc = floor_q30(acc, sq) - 64'sd693598668;
        acc = floor_q30(acc, sq) + 64'sd1686629713;
        acc = floor_q30(acc, x);
        if (acc < 0)
        begin
            acc = 0;
        end
        if (acc > (64'sd1 <<< 30))
        begin
            acc = 64'sd1 <<< 30;
        end
        return acc;
    endfunction

    function automatic logic signed [63:0] sine_of(logic [31:0] ph);
        logic [1:0]         quad;
        int                 a;
        logic signed [63:0] mag;
        quad = ph[31:30];
        a = int'(ph[29:30-SINE_ROM_BITS]);
        mag = quad[0] ? quarter_wave[(1 << SINE_ROM_BITS) - a] : quarter_wave[a];
        return quad[1] ? -mag : mag;
    endfunction

    function automatic sample_beat_t predict_sample(logic [47:0] n);
        sample_beat_t       beat;
        logic [127:0]       d;
        logic [127:0]       p;
        logic [127:0]       within_cnt;
        logic [127:0]       size;
        logic [127:0]       idx;
        logic [31:0]        ph;
        logic signed [63:0] v;
        logic signed [63:0] m;
        logic signed [127:0] prod;
        logic [127:0]       mag;
        beat.sample = '0;
        beat.clipped = 1'b0;
        if (cur_rate == 0 || cur_mode == MODE_ZERO || cur_mode > MODE_TABLE_SECOND)
        begin
            return beat;
        end
        d = 128'(cur_rate) * 1000;
        p = ((128'(n) % d) * (128'(cur_freq) % d)) % d;
        within_cnt = 128'(n) % 128'(cur_rate);
        size = (cur_size > TABLE_DEPTH) ? 128'(TABLE_DEPTH) : 128'(cur_size);
        if (cur_mode == MODE_TABLE_CYCLE || cur_mode == MODE_TABLE_SECOND)
        begin
            if (size != 0)
            begin
                idx = (cur_mode == MODE_TABLE_SECOND) ? (within_cnt * size) / 128'(cur_rate)
                                                      : (p * size) / d;
                if (idx >= size)
                begin
                    idx = size - 1;
                end
                beat.sample = wave_mem[idx[11:0]];
            end
            return beat;
        end
        ph = 32'((p << 32) / d) + {cur_phase, 16'h0000};
        case (cur_mode)
            MODE_SINE:   v = sine_of(ph);
            MODE_COSINE: v = sine_of(ph + 32'h4000_0000);
            MODE_SQUARE: v = ph[31] ? -(64'sd1 <<< 30) : (64'sd1 <<< 30);
            default:     v = ph[31] ? (64'sd3 <<< 30) - $signed({32'd0, ph})
                                    : $signed({32'd0, ph}) - (64'sd1 <<< 30);
        endcase
        m = 64'sd65536;
        for (int i = 0; i < ((cur_steps > STEP_SLOTS) ? STEP_SLOTS : cur_steps); i++)
        begin
            if (within_cnt >= 128'(onset_mem[i]))
            begin
                m = m + 64'($signed(gain_mem[i]));
            end
        end
        prod = 128'(v * 64'($signed(cur_amp))) * 128'(m);
        mag = (prod < 0) ? 128'(-prod) : 128'(prod);
        mag = mag >> 46;
        if (prod >= 0)
        begin
            if (mag > 128'h7FFF_FFFF)
            begin
                beat.sample = 32'h7FFF_FFFF;
                beat.clipped = 1'b1;
            end
            else
            begin
                beat.sample = mag[31:0];
            end
        end
        else if (mag > 128'h8000_0000)
        begin
            beat.sample = 32'h8000_0000;
            beat.clipped = 1'b1;
        end
        else
        begin
            beat.sample = -mag[31:0];
        end
        return beat;
    endfunction

    // results sit from one rising edge to the next; sample mid-cycle
    always @(negedge clk)
    begin
        sample_beat_t want;
        if (rst_n && done)
        begin
            if (pending_samples.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected beat: sample %0d clipped %0d", sample, clipped);
                end
            end
            else
            begin
                want = pending_samples.pop_front();
                if (sample !== want.sample || clipped !== want.clipped)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch: expected sample %0d clipped %0d, got %0d %0d",
                                 want.sample, want.clipped, sample, clipped);
                    end
                end
            end
        end
    end

    // returns on the accepting edge with start still high
    task automatic send_cmd(gen_cmd_t c);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        opcode <= c.op;
        sample_index <= c.n;
        entry_address <= c.addr;
        entry_value <= c.value;
        step_slot <= c.slot;
        step_time_samples <= c.onset;
        step_coefficient <= c.gain;
        forever
        begin
            @(negedge clk);
            if (!busy)
            begin
                break;
            end
        end
        @(posedge clk);
        case (c.op)
            OP_GENERATE:    pending_samples.push_back(predict_sample(c.n));
            OP_WRITE_TABLE: wave_mem[c.addr] = c.value;
            OP_WRITE_STEP:
            begin
                onset_mem[c.slot] = c.onset;
                gain_mem[c.slot] = c.gain;
            end
            default: ;
        endcase
    endtask

    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (pending_samples.size() != 0 || busy)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic cfg_put(reg_index_t idx, logic [31:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        case (idx)
            REG_MODE:       cur_mode = value[2:0];
            REG_AMPLITUDE:  cur_amp = value;
            REG_FREQUENCY:  cur_freq = value;
            REG_PHASE:      cur_phase = value[15:0];
            REG_RATE:       cur_rate = value[23:0];
            REG_TABLE_SIZE: cur_size = value[12:0];
            REG_STEP_COUNT: cur_steps = value[3:0];
            default:        ;
        endcase
    endtask

    task automatic setup(logic [2:0] md, logic [31:0] amp, logic [31:0] freq,
                         logic [15:0] ph, logic [23:0] rate, logic [12:0] size,
                         logic [3:0] steps);
        settle();
        cfg_put(REG_MODE, 32'(md));
        cfg_put(REG_AMPLITUDE, amp);
        cfg_put(REG_FREQUENCY, freq);
        cfg_put(REG_PHASE, 32'(ph));
        cfg_put(REG_RATE, 32'(rate));
        cfg_put(REG_TABLE_SIZE, 32'(size));
        cfg_put(REG_STEP_COUNT, 32'(steps));
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic gen(logic [47:0] n);
        gen_cmd_t c;
        c = '{OP_GENERATE, n, 12'($urandom), 32'($urandom), 3'($urandom),
              24'($urandom), 24'($urandom)};
        send_cmd(c);
    endtask

    task automatic test_reset_defaults();
        gen(48'd0);
        gen(48'hFFFF_FFFF_FFFF);
    endtask

    // the table entries in use and every step slot get a value before any read
    task automatic test_fill_stores();
        gen_cmd_t c;
        for (int i = 0; i < FILL_DEPTH; i++)
        begin
            c = '{OP_WRITE_TABLE, 48'({$urandom, $urandom}), 12'(i), 32'($urandom),
                  3'd0, 24'd0, 24'd0};
            if (i == 0)
            begin
                c.value = 32'sh7FFF_FFFF;
            end
            if (i == FILL_DEPTH - 1)
            begin
                c.value = 32'sh8000_0000;
            end
            send_cmd(c);
        end
        for (int i = 0; i < STEP_SLOTS; i++)
        begin
            c = '{OP_WRITE_STEP, '0, '0, '0, 3'(i), 24'($urandom_range(3000)),
                  24'($signed($urandom_range(65536)) - 32768)};
            send_cmd(c);
        end
        c = '{OP_UNUSED, 48'({$urandom, $urandom}), 12'($urandom), 32'($urandom),
              3'($urandom), 24'($urandom), 24'($urandom)};
        send_cmd(c);
    endtask

    task automatic test_wave_modes();
        for (int md = MODE_SINE; md <= MODE_TABLE_SECOND; md++)
        begin
            setup(3'(md), 32'd1000000, 32'd50000, 16'd0, 24'd4000, 13'd64, 4'd0);
            gen(48'd0);
            gen(48'd17);
            gen(48'hFFFF_FFFF_FFFF);
        end
    endtask

    task automatic test_corner_cases();
        gen_cmd_t c;
        // zero rate and the unused mode code both give zero
        setup(MODE_SINE, 32'd5000, 32'd1000, 16'h1234, 24'd0, 13'd16, 4'd8);
        gen(48'd123);
        setup(3'd7, 32'd5000, 32'd1000, 16'd0, 24'd1000, 13'd16, 4'd0);
        gen(48'd123);
        // frequency zero reads entry zero of a full-depth table; then an empty table
        setup(MODE_TABLE_CYCLE, 32'd0, 32'd0, 16'hFFFF, 24'd1, 13'd4096, 4'd0);
        gen(48'd999);
        setup(MODE_TABLE_SECOND, 32'd0, 32'hFFFF_FFFF, 16'd0, 24'hFF_FFFF, 13'd0, 4'd0);
        gen(48'd999);
        // oversized table with the index landing on the first entry
        setup(MODE_TABLE_SECOND, 32'd0, 32'hFFFF_FFFF, 16'd0, 24'hFF_FFFF, 13'h1FFF, 4'd0);
        gen(48'hFFFF_FF00_0000);
        // large positive gain with full-scale amplitude of either sign saturates
        c = '{OP_WRITE_STEP, '0, '0, '0, 3'd0, 24'd0, 24'sh7F_FFFF};
        send_cmd(c);
        setup(MODE_SQUARE, 32'h7FFF_FFFF, 32'd1000, 16'd0, 24'd1000, 13'd1, 4'hF);
        gen(48'd0);
        setup(MODE_SQUARE, 32'h8000_0000, 32'd1000, 16'h8000, 24'd1000, 13'd1, 4'd1);
        gen(48'd0);
        setup(MODE_TRIANGLE, 32'h8000_0000, 32'd1000, 16'h4000, 24'd1000, 13'd1, 4'd0);
        gen(48'd0);
        c = '{OP_WRITE_STEP, '0, '0, '0, 3'd0, 24'hFF_FFFF, 24'sh80_0000};
        send_cmd(c);
        gen(48'd500);
    endtask

    task automatic random_setup();
        logic [31:0] amp;
        logic [31:0] freq;
        logic [23:0] rate;
        logic [12:0] size;
        amp = $urandom;
        case ($urandom_range(5))
            0: amp = 32'h7FFF_FFFF;
            1: amp = 32'h8000_0000;
            2: amp = 32'($signed($urandom_range(2000000)) - 1000000);
            default: ;
        endcase
        freq = $urandom;
        case ($urandom_range(4))
            0: freq = 32'd0;
            1: freq = $urandom_range(1000000);
            default: ;
        endcase
        rate = 24'($urandom_range(10000));
        case ($urandom_range(9))
            0: rate = 24'hFF_FFFF;
            1: rate = 24'($urandom);
            2: rate = 24'd0;
            default: ;
        endcase
        size = 13'($urandom_range(FILL_DEPTH));
        case ($urandom_range(4))
            0: size = 13'(FILL_DEPTH);
            default: ;
        endcase
        setup(3'($urandom), amp, freq, 16'($urandom), rate, size, 4'($urandom));
    endtask

    task automatic test_random_traffic(int gaps);
        gen_cmd_t c;
        idle_pct = gaps;
        for (int k = 0; k < 8; k++)
        begin
            random_setup();
            for (int i = 0; i < RANDOM_ITEMS; i++)
            begin
                c = '{OP_GENERATE, 48'({$urandom, $urandom}), 12'($urandom), 32'($urandom),
                      3'($urandom), 24'($urandom), 24'($urandom)};
                if ($urandom_range(2) == 0)
                begin
                    c.n = 48'($urandom_range(20000));
                end
                case ($urandom_range(15))
                    0, 1:    c.op = OP_WRITE_TABLE;
                    2, 3:    c.op = OP_WRITE_STEP;
                    4:       c.op = OP_UNUSED;
                    default: ;
                endcase
                if (c.op == OP_WRITE_STEP && $urandom_range(1) == 0)
                begin
                    c.onset = 24'($urandom_range(5000));
                    c.gain = 24'($signed($urandom_range(131072)) - 65536);
                end
                send_cmd(c);
            end
        end
    endtask

    initial
    begin
        for (int i = 0; i < ROM_DEPTH; i++)
        begin
            quarter_wave[i] = poly_sine(i);
        end
        cur_mode = MODE_ZERO;
        cur_amp = '0;
        cur_freq = 32'd50000;
        cur_phase = '0;
        cur_rate = 24'd4000;
        cur_size = 13'd1;
        cur_steps = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_fill_stores();
        test_wave_modes();
        test_corner_cases();
        test_random_traffic(0);
        test_random_traffic(77);
        test_random_traffic(0);
        test_random_traffic(30);
        settle();
        if (mismatches == 0)
        begin
            $display("PASS waveform_sample_generator");
        end
        else
        begin
            $display("FAIL waveform_sample_generator");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/wsg_pkg.sv
sv/wsg_arith.sv
sv/wsg_sine_rom.sv
sv/wsg_wave_ram.sv
sv/waveform_sample_generator.sv
tb/sv/tb_waveform_sample_generator.sv
